// ===== sv/length_prefixed_message_ring_unit_macros.svh =====
`ifndef LENGTH_PREFIXED_MESSAGE_RING_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPMR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPMR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lpmr_pkg.sv =====
package lpmr_pkg;

  localparam int REQ_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 11;
  localparam int FREE_W   = 11;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_SEND_HDR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEND_DATA = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RECV      = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,       // capture the input beat, clear the result
    OP_STATUS,      // result carries a status code only, no state change
    OP_SEND_HDR,    // store length byte, reserve space
    OP_SEND_DATA,   // store one data byte
    OP_RECV_LEN,    // take the length byte of the oldest message
    OP_RECV_FIRST,  // take the first data byte after the length
    OP_RECV_NEXT    // take a following data byte
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [STATUS_W-1:0] code;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             send_active;
    logic             recv_active;
    logic             ring_empty;
    logic             room_ok;
    logic             len_zero;
  } sts_t;

endpackage

// ===== sv/length_prefixed_message_ring_unit.sv =====
// Length-prefixed message ring: a byte ring that stores each message as a
// length byte followed by its data bytes. A send header (req_type 0) reserves
// length+1 bytes only when free space strictly exceeds length+1; the data
// bytes follow one per send-data beat (req_type 1), and a message becomes
// readable only after its last byte is written. Each receive beat (req_type 2)
// returns one byte of the oldest committed message with first/last marks and
// the message length; the space is released after the last byte. Every input
// beat yields exactly one result beat with a status (ok, no space, empty,
// ignored) and the free space after the step. The block takes one input beat
// at a time: a send, an ignored or a refused beat passes decode and the
// output step, a following byte of a receive adds a data read, a zero-length
// message a length read, and a first byte a length read, a wait and a data
// read; the reads use the single registered read port of the ring memory,
// which must fetch the length byte and then the data byte one after the
// other. A stalled result is held in the output register while the next input
// beat is taken. Writing buffer_size (clamped to 2..BUF_DEPTH) empties the
// ring and may only be done while the block is idle; the ring needs no
// clearing pass after reset.
`include "length_prefixed_message_ring_unit_macros.svh"

module length_prefixed_message_ring_unit
  import lpmr_pkg::*;
#(
  parameter int BUF_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [BYTE_W-1:0]   data_in_i,
  input  logic [BYTE_W-1:0]   msg_len_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTE_W-1:0]   data_out_o,
  output logic [BYTE_W-1:0]   msg_len_out_o,
  output logic                first_byte_o,
  output logic                last_byte_o,
  output logic [FREE_W-1:0]   free_space_o
);

  cmd_t cmd;
  sts_t sts;

  // The user must write configuration only while idle (not enforced here), so always take the beat.
  assign cfg_ready_o = 1'b1;

  // Sequencer: decode, memory read steps, result hand-off.
  lpmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Pointers, free count, ring memory and result registers.
  lpmr_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .data_in_i     (data_in_i),
    .msg_len_i     (msg_len_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .msg_len_out_o (msg_len_out_o),
    .first_byte_o  (first_byte_o),
    .last_byte_o   (last_byte_o),
    .free_space_o  (free_space_o)
  );

  // An accepted beat keeps the input side busy in the next cycle.
  `LPMR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input accepted again while previous beat in work")
  // A message start is only reported on a successful receive.
  `LPMR_ASSERT_NOW(a_first_is_ok, clk_i, rst_ni, out_valid_o && first_byte_o, status_o == ST_OK, "first mark on a failed result")
  // Failed or ignored steps carry no received byte.
  `LPMR_ASSERT_NOW(a_fail_is_blank, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), (data_out_o == '0) && (msg_len_out_o == '0) && !first_byte_o && !last_byte_o, "receive fields set on a non-ok result")

endmodule

// ===== sv/lpmr_ctrl.sv =====
module lpmr_ctrl
  import lpmr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_LEN,
    S_RD_WAIT,
    S_RD_FIRST,
    S_RD_DATA,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '{op: OP_NONE, code: ST_OK, out_load: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_OUT;
        case (sts_i.req)
          REQ_SEND_HDR: begin
            if (sts_i.send_active) begin
              cmd_o.op   = OP_STATUS;
              cmd_o.code = ST_IGNORED;
            end else if (sts_i.room_ok) begin
              cmd_o.op = OP_SEND_HDR;
            end else begin
              cmd_o.op   = OP_STATUS;
              cmd_o.code = ST_NO_SPACE;
            end
          end
          REQ_SEND_DATA: begin
            if (sts_i.send_active) begin
              cmd_o.op = OP_SEND_DATA;
            end else begin
              cmd_o.op   = OP_STATUS;
              cmd_o.code = ST_IGNORED;
            end
          end
          REQ_RECV: begin
            if (sts_i.recv_active) begin
              state_d = S_RD_DATA;
            end else if (sts_i.ring_empty) begin
              cmd_o.op   = OP_STATUS;
              cmd_o.code = ST_EMPTY;
            end else begin
              state_d = S_RD_LEN;
            end
          end
          default: begin
            cmd_o.op   = OP_STATUS;
            cmd_o.code = ST_IGNORED;
          end
        endcase
      end
      S_RD_LEN: begin
        cmd_o.op = OP_RECV_LEN;
        state_d  = sts_i.len_zero ? S_OUT : S_RD_WAIT;
      end
      S_RD_WAIT: begin
        state_d = S_RD_FIRST;
      end
      S_RD_FIRST: begin
        cmd_o.op = OP_RECV_FIRST;
        state_d  = S_OUT;
      end
      S_RD_DATA: begin
        cmd_o.op = OP_RECV_NEXT;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/lpmr_dp.sv =====
module lpmr_dp
  import lpmr_pkg::*;
#(
  parameter int BUF_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [BYTE_W-1:0]   data_in_i,
  input  logic [BYTE_W-1:0]   msg_len_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTE_W-1:0]   data_out_o,
  output logic [BYTE_W-1:0]   msg_len_out_o,
  output logic                first_byte_o,
  output logic                last_byte_o,
  output logic [FREE_W-1:0]   free_space_o
);

  localparam int PW = $clog2(BUF_DEPTH);
  localparam int SW = $clog2(BUF_DEPTH + 1);
  localparam int CW = (SW > CFG_W) ? SW : CFG_W;
  localparam int FW = (SW > BYTE_W + 1) ? SW + 1 : BYTE_W + 2;
  localparam int SIZE_RST = (BUF_DEPTH < 1024) ? BUF_DEPTH : 1024;

  function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p,
                                               input logic [SW-1:0] sz);
    logic [PW:0] n;
    n = {1'b0, p} + (PW + 1)'(1);
    wrap_next = (n >= (PW + 1)'(sz)) ? '0 : n[PW-1:0];
  endfunction

  logic [BYTE_W-1:0] mem_q [BUF_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_wdata;

  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     cm_ptr_q, cm_ptr_d;
  logic [SW-1:0]     free_q, free_d;
  logic [SW-1:0]     size_q, size_d;
  logic [BYTE_W-1:0] send_rem_q, send_rem_d;
  logic              send_act_q, send_act_d;
  logic [BYTE_W-1:0] recv_rem_q, recv_rem_d;
  logic              recv_act_q, recv_act_d;
  logic [BYTE_W-1:0] recv_len_q, recv_len_d;

  logic [REQ_W-1:0]    req_q;
  logic [BYTE_W-1:0]   din_q, len_q;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [BYTE_W-1:0]   res_dout_q, res_dout_d;
  logic [BYTE_W-1:0]   res_lout_q, res_lout_d;
  logic                res_first_q, res_first_d;
  logic                res_last_q, res_last_d;

  logic [CW-1:0]     cfg_ext;
  logic [FW-1:0]     len_p1;
  logic [FW-1:0]     recv_len_p1;
  logic [BYTE_W-1:0] rem_dec;

  assign cfg_ext     = CW'(cfg_data_i);
  assign len_p1      = FW'(len_q) + FW'(1);
  assign recv_len_p1 = FW'(recv_len_q) + FW'(1);

  assign sts_o.req         = req_q;
  assign sts_o.send_active = send_act_q;
  assign sts_o.recv_active = recv_act_q;
  assign sts_o.ring_empty  = (rd_ptr_q == cm_ptr_q);
  assign sts_o.room_ok     = (FW'(free_q) > len_p1);
  assign sts_o.len_zero    = (rdata_q == '0);

  always_comb begin
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    cm_ptr_d     = cm_ptr_q;
    free_d       = free_q;
    size_d       = size_q;
    send_rem_d   = send_rem_q;
    send_act_d   = send_act_q;
    recv_rem_d   = recv_rem_q;
    recv_act_d   = recv_act_q;
    recv_len_d   = recv_len_q;
    res_status_d = res_status_q;
    res_dout_d   = res_dout_q;
    res_lout_d   = res_lout_q;
    res_first_d  = res_first_q;
    res_last_d   = res_last_q;
    mem_we       = 1'b0;
    mem_wdata    = din_q;
    rem_dec      = '0;

    if (cfg_we_i) begin
      // Clamp the new size, then empty the ring.
      if (cfg_ext < CW'(2)) begin
        size_d = SW'(2);
      end else if (cfg_ext > CW'(BUF_DEPTH)) begin
        size_d = SW'(BUF_DEPTH);
      end else begin
        size_d = SW'(cfg_ext);
      end
      rd_ptr_d   = '0;
      wr_ptr_d   = '0;
      cm_ptr_d   = '0;
      free_d     = size_d;
      send_rem_d = '0;
      send_act_d = 1'b0;
      recv_rem_d = '0;
      recv_act_d = 1'b0;
      recv_len_d = '0;
    end else begin
      case (cmd_i.op)
        OP_LATCH: begin
          res_status_d = ST_OK;
          res_dout_d   = '0;
          res_lout_d   = '0;
          res_first_d  = 1'b0;
          res_last_d   = 1'b0;
        end
        OP_STATUS: begin
          res_status_d = cmd_i.code;
        end
        OP_SEND_HDR: begin
          mem_we     = 1'b1;
          mem_wdata  = len_q;
          wr_ptr_d   = wrap_next(wr_ptr_q, size_q);
          free_d     = SW'(FW'(free_q) - len_p1);
          send_rem_d = len_q;
          if (len_q == '0) begin
            cm_ptr_d = wr_ptr_d;
          end else begin
            send_act_d = 1'b1;
          end
        end
        OP_SEND_DATA: begin
          mem_we     = 1'b1;
          wr_ptr_d   = wrap_next(wr_ptr_q, size_q);
          send_rem_d = send_rem_q - BYTE_W'(1);
          if (send_rem_d == '0) begin
            cm_ptr_d   = wr_ptr_d;
            send_act_d = 1'b0;
          end
        end
        OP_RECV_LEN: begin
          rd_ptr_d    = wrap_next(rd_ptr_q, size_q);
          res_first_d = 1'b1;
          res_lout_d  = rdata_q;
          recv_len_d  = rdata_q;
          if (rdata_q == '0) begin
            res_last_d = 1'b1;
            free_d     = free_q + SW'(1);
          end
        end
        OP_RECV_FIRST: begin
          res_dout_d = rdata_q;
          rd_ptr_d   = wrap_next(rd_ptr_q, size_q);
          rem_dec    = recv_len_q - BYTE_W'(1);
          recv_rem_d = rem_dec;
          if (rem_dec == '0) begin
            res_last_d = 1'b1;
            free_d     = SW'(FW'(free_q) + recv_len_p1);
          end else begin
            recv_act_d = 1'b1;
          end
        end
        OP_RECV_NEXT: begin
          res_dout_d = rdata_q;
          rd_ptr_d   = wrap_next(rd_ptr_q, size_q);
          res_lout_d = recv_len_q;
          rem_dec    = recv_rem_q - BYTE_W'(1);
          recv_rem_d = rem_dec;
          if (rem_dec == '0) begin
            res_last_d = 1'b1;
            recv_act_d = 1'b0;
            free_d     = SW'(FW'(free_q) + recv_len_p1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Ring store: one write port, one registered read port at the read pointer.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      cm_ptr_q   <= '0;
      free_q     <= SW'(SIZE_RST);
      size_q     <= SW'(SIZE_RST);
      send_rem_q <= '0;
      send_act_q <= 1'b0;
      recv_rem_q <= '0;
      recv_act_q <= 1'b0;
      recv_len_q <= '0;
    end else begin
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      cm_ptr_q   <= cm_ptr_d;
      free_q     <= free_d;
      size_q     <= size_d;
      send_rem_q <= send_rem_d;
      send_act_q <= send_act_d;
      recv_rem_q <= recv_rem_d;
      recv_act_q <= recv_act_d;
      recv_len_q <= recv_len_d;
    end
  end

  // Input beat capture, result staging and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      req_q <= req_type_i;
      din_q <= data_in_i;
      len_q <= msg_len_i;
    end
    res_status_q <= res_status_d;
    res_dout_q   <= res_dout_d;
    res_lout_q   <= res_lout_d;
    res_first_q  <= res_first_d;
    res_last_q   <= res_last_d;
    if (cmd_i.out_load) begin
      status_o      <= res_status_q;
      data_out_o    <= res_dout_q;
      msg_len_out_o <= res_lout_q;
      first_byte_o  <= res_first_q;
      last_byte_o   <= res_last_q;
      free_space_o  <= FREE_W'(free_q);
    end
  end

endmodule

// ===== test/length_prefixed_message_ring_unit_test.sv =====
`timescale 1ns / 1ps

module length_prefixed_message_ring_unit_test;
  import lpmr_pkg::*;

  // The package names only the three live request codes; the fourth is unused.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned RING_DEPTH = 1024;

  // One result beat, field by field.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data;
    logic [BYTE_W-1:0]   len;
    logic                first;
    logic                last;
    logic [FREE_W-1:0]   free;
  } ring_reply_t;

  // Mirror of the ring: keeps its own store, pointers and message state, works
  // out the reply each accepted request beat will produce, and queues it until
  // the block returns the matching result beat.
  class ring_scoreboard;
    logic [7:0]  ring_mem [RING_DEPTH];
    int unsigned ring_size, rd_ptr, wr_ptr, commit_ptr, free_cnt;
    int unsigned send_left, recv_left, recv_len;
    bit          sending, receiving;
    ring_reply_t replies_due [$];
    int          errors;

    function new();
      foreach (ring_mem[i]) ring_mem[i] = '0;
      ring_size = RING_DEPTH;
      errors = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      rd_ptr = 0;
      wr_ptr = 0;
      commit_ptr = 0;
      free_cnt = ring_size;
      send_left = 0;
      sending = 0;
      recv_left = 0;
      receiving = 0;
      recv_len = 0;
    endfunction

    // Clamp the new size and empty the ring, aborting any message in flight.
    function void resize(logic [CFG_W-1:0] size);
      ring_size = 32'(size);
      if (ring_size < 2) ring_size = 2;
      if (ring_size > RING_DEPTH) ring_size = RING_DEPTH;
      clear_ring();
    endfunction

    // Wrap after any byte, the length byte included.
    function int unsigned step_ptr(int unsigned p);
      return (p + 1 >= ring_size) ? 0 : p + 1;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Advance the mirror by one request beat; return the predicted status.
    function logic [STATUS_W-1:0] accept_request(logic [REQ_W-1:0] req,
                                                 logic [7:0] din, logic [7:0] len);
      ring_reply_t r;
      int unsigned l;
      r = '0;
      r.status = ST_OK;
      case (req)
        REQ_SEND_HDR: begin
          if (sending) begin
            r.status = ST_IGNORED;
          end else if (free_cnt > len + 1) begin
            ring_mem[wr_ptr] = len;
            wr_ptr = step_ptr(wr_ptr);
            free_cnt -= len + 1;
            send_left = 32'(len);
            if (len == 0) commit_ptr = wr_ptr;
            else sending = 1;
          end else begin
            r.status = ST_NO_SPACE;
          end
        end
        REQ_SEND_DATA: begin
          if (!sending) begin
            r.status = ST_IGNORED;
          end else begin
            ring_mem[wr_ptr] = din;
            wr_ptr = step_ptr(wr_ptr);
            send_left = (send_left - 1) & 8'hFF;
            // Publish the message only once its last byte is in.
            if (send_left == 0) begin
              commit_ptr = wr_ptr;
              sending = 0;
            end
          end
        end
        REQ_RECV: begin
          if (!receiving) begin
            if (rd_ptr == commit_ptr) begin
              r.status = ST_EMPTY;
            end else begin
              l = 32'(ring_mem[rd_ptr]);
              rd_ptr = step_ptr(rd_ptr);
              r.first = 1'b1;
              r.len = 8'(l);
              if (l == 0) begin
                r.last = 1'b1;
                free_cnt += 1;
              end else begin
                r.data = ring_mem[rd_ptr];
                rd_ptr = step_ptr(rd_ptr);
                recv_left = l - 1;
                recv_len = l;
                if (recv_left == 0) begin
                  r.last = 1'b1;
                  free_cnt += l + 1;
                end else begin
                  receiving = 1;
                end
              end
            end
          end else begin
            r.data = ring_mem[rd_ptr];
            rd_ptr = step_ptr(rd_ptr);
            r.len = 8'(recv_len);
            recv_left = (recv_left - 1) & 8'hFF;
            if (recv_left == 0) begin
              r.last = 1'b1;
              receiving = 0;
              free_cnt += recv_len + 1;
            end
          end
        end
        default: r.status = ST_IGNORED;
      endcase
      r.free = FREE_W'(free_cnt);
      replies_due.push_back(r);
      return r.status;
    endfunction

    task report(string what);
      errors++;
      $display("%0t: mismatch, %s", $time, what);
    endtask

    task match(string field, int got, int want);
      if (got != want) report($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    task check_reply(ring_reply_t got);
      ring_reply_t want;
      if (replies_due.size() == 0) begin
        report("result beat with no request outstanding");
        return;
      end
      want = replies_due.pop_front();
      match("status", int'(got.status), int'(want.status));
      match("data_out", int'(got.data), int'(want.data));
      match("msg_len_out", int'(got.len), int'(want.len));
      match("first_byte", int'(got.first), int'(want.first));
      match("last_byte", int'(got.last), int'(want.last));
      match("free_space", int'(got.free), int'(want.free));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [REQ_W-1:0]    req_type_i = REQ_RECV;
  logic [BYTE_W-1:0]   data_in_i = '0;
  logic [BYTE_W-1:0]   msg_len_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [BYTE_W-1:0]   data_out_o;
  logic [BYTE_W-1:0]   msg_len_out_o;
  logic                first_byte_o;
  logic                last_byte_o;
  logic [FREE_W-1:0]   free_space_o;

  ring_scoreboard sb = new();

  bit in_idle_on = 1'b0;   // sender inserts random gaps between beats
  bit out_idle_on = 1'b0;  // receiver stalls at random after each beat
  int useful_beats = 0;    // accepted beats that the block did not ignore
  int stall_left = 0;

  length_prefixed_message_ring_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .data_in_i     (data_in_i),
    .msg_len_i     (msg_len_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .msg_len_out_o (msg_len_out_o),
    .first_byte_o  (first_byte_o),
    .last_byte_o   (last_byte_o),
    .free_space_o  (free_space_o)
  );

  always #6 clk_i = ~clk_i;

  // Result side: sample at the edge (pre-update values), check each accepted
  // beat, then hold stall for a freshly drawn number of cycles.
  always @(posedge clk_i) begin
    ring_reply_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_o;
      got.data = data_out_o;
      got.len = msg_len_out_o;
      got.first = first_byte_o;
      got.last = last_byte_o;
      got.free = free_space_o;
      sb.check_reply(got);
      stall_left = out_idle_on ? $urandom_range(0, 12) : 0;
      if (stall_left != 0) out_stall_i <= 1'b1;
    end else if (out_stall_i) begin
      stall_left--;
      if (stall_left == 0) out_stall_i <= 1'b0;
    end
  end

  // Present one request beat and hold it until taken. Valid stays high into the
  // next beat when no gap is drawn, so it never drops and rises in one step.
  task automatic put_beat(input logic [REQ_W-1:0] req, input logic [7:0] din,
                          input logic [7:0] len, output logic [STATUS_W-1:0] verdict);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    data_in_i <= din;
    msg_len_i <= len;
    do @(posedge clk_i); while (in_stall_o);
    verdict = sb.accept_request(req, din, len);
    if (verdict != ST_IGNORED) useful_beats++;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write buffer_size on the config channel; the block must be idle.
  task automatic resize_ring(input logic [CFG_W-1:0] size);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.resize(size);
  endtask

  // One message: header then its data bytes. Finish a message left open first,
  // sometimes with a stray header that the block must ignore.
  task automatic send_message();
    logic [STATUS_W-1:0] verdict;
    int pick, len, cut, left;
    if (sb.sending) begin
      if ($urandom_range(0, 1)) begin
        put_beat(REQ_SEND_HDR, 8'($urandom), 8'($urandom), verdict);
      end
      left = sb.send_left;
      for (int i = 0; i < left; i++) begin
        put_beat(REQ_SEND_DATA, 8'($urandom), 8'($urandom), verdict);
      end
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 15 && sb.free_cnt <= 257) begin
      // Hug the strict space limit from both sides.
      len = int'(sb.free_cnt) - 2 + $urandom_range(0, 1);
    end else if (pick < 65) begin
      len = $urandom_range(0, 8);
    end else if (pick < 90) begin
      len = $urandom_range(9, 40);
    end else begin
      len = $urandom_range(41, 255);
    end
    if (len < 0) len = 0;
    if (len > 255) len = 255;
    cut = len;
    // Now and then leave the message unfinished.
    if ($urandom_range(0, 99) < 8) cut = $urandom_range(0, len);
    put_beat(REQ_SEND_HDR, 8'($urandom), 8'(len), verdict);
    if (verdict == ST_OK) begin
      for (int i = 0; i < cut; i++) begin
        put_beat(REQ_SEND_DATA, 8'($urandom), 8'($urandom), verdict);
      end
    end
  endtask

  // A burst of receive beats; stop early once the ring runs dry.
  task automatic fetch_burst();
    logic [STATUS_W-1:0] verdict;
    int count;
    count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      put_beat(REQ_RECV, 8'($urandom), 8'($urandom), verdict);
      if (verdict == ST_EMPTY && i > 0) break;
    end
  endtask

  function automatic logic [REQ_W-1:0] REQ_REQ_NOISE();
    return REQ_W'($urandom_range(0, 3));
  endfunction

  // Mostly well-formed traffic, the rest raw noise over every request code.
  task automatic run_traffic(input int target);
    logic [STATUS_W-1:0] verdict;
    int goal, pick;
    goal = useful_beats + target;
    while (useful_beats < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_message();
      else if (pick < 82) fetch_burst();
      else put_beat(REQ_REQ_NOISE(), 8'($urandom), 8'($urandom), verdict);
    end
  endtask

  // Hand-picked beats at the reset size: every request code and the corner
  // cases of the message protocol.
  task automatic run_directed();
    logic [STATUS_W-1:0] v;
    put_beat(REQ_RECV, 8'h00, 8'h00, v);       // nothing committed yet
    put_beat(REQ_SEND_DATA, 8'hFF, 8'h00, v);  // data with no header
    put_beat(REQ_UNUSED, 8'hFF, 8'hFF, v);     // unused request code
    put_beat(REQ_SEND_HDR, 8'h00, 8'h00, v);   // zero-length message
    put_beat(REQ_RECV, 8'h00, 8'h00, v);
    put_beat(REQ_SEND_HDR, 8'h00, 8'd3, v);
    put_beat(REQ_SEND_DATA, 8'h00, 8'h00, v);
    put_beat(REQ_SEND_HDR, 8'h00, 8'd5, v);    // header while a send is open
    put_beat(REQ_SEND_DATA, 8'hFF, 8'hFF, v);
    put_beat(REQ_SEND_DATA, 8'hA5, 8'h00, v);
    put_beat(REQ_RECV, 8'h00, 8'h00, v);
    put_beat(REQ_RECV, 8'h00, 8'h00, v);
    put_beat(REQ_RECV, 8'h00, 8'h00, v);
    put_beat(REQ_SEND_HDR, 8'h00, 8'd1, v);    // single-byte message
    put_beat(REQ_SEND_DATA, 8'h5A, 8'h00, v);
    put_beat(REQ_RECV, 8'h00, 8'h00, v);
    put_beat(REQ_SEND_HDR, 8'h00, 8'd2, v);
    put_beat(REQ_SEND_DATA, 8'h11, 8'h00, v);
    put_beat(REQ_RECV, 8'h00, 8'h00, v);       // half-written message is hidden
    put_beat(REQ_SEND_DATA, 8'h22, 8'h00, v);
    put_beat(REQ_RECV, 8'h00, 8'h00, v);
    put_beat(REQ_RECV, 8'h00, 8'h00, v);
  endtask

  // Smallest ring: only zero-length messages fit, and only one at a time.
  task automatic run_tiny_ring();
    logic [STATUS_W-1:0] v;
    put_beat(REQ_SEND_HDR, 8'h00, 8'd255, v);  // far too long
    put_beat(REQ_SEND_HDR, 8'h00, 8'd0, v);
    put_beat(REQ_SEND_HDR, 8'h00, 8'd0, v);    // free equals length+1: refused
    put_beat(REQ_RECV, 8'h00, 8'h00, v);
  endtask

  initial begin
    logic [CFG_W-1:0] size_plan [10];
    size_plan = '{11'h7FF, 11'd0, 11'd3, 11'd17, 11'd1, 11'd300, 11'd1024,
                  11'd2, 11'd64, 11'd0};
    size_plan[9] = CFG_W'($urandom_range(4, 1023));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size first, directed then random.
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    run_directed();
    run_traffic(110);

    foreach (size_plan[p]) begin
      // Wait out every result before touching the size register.
      drain_replies();
      resize_ring(size_plan[p]);
      // Keep one phase fully back-to-back on both sides.
      in_idle_on = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      out_idle_on = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (p == 1) run_tiny_ring();
      run_traffic(100);
    end

    drain_replies();
    repeat (24) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results still outstanding at end of run");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Catch a hung handshake.
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lpmr_pkg.sv
sv/lpmr_ctrl.sv
sv/lpmr_dp.sv
sv/length_prefixed_message_ring_unit.sv
test/length_prefixed_message_ring_unit_test.sv
